>>> rtl/pbce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbce_pkg: shared types and constants
// Widths, register indexes and the sequencer state type of the estimator.
// ----------------------------------------------------------------------------
package pbce_pkg;

   localparam int SLOTS        = 64;
   localparam int SLOT_BITS    = $clog2(SLOTS);
   localparam int HEADER_BYTES = 28;
   localparam int TIME_BITS    = 48;
   localparam int DISP_BITS    = 49;
   localparam int SUM_BITS     = 50;
   localparam int CAP_BITS     = 40;
   localparam int GAP_BITS     = 32;
   localparam int DIV_BITS     = 64;
   localparam int CNT_BITS     = $clog2(DIV_BITS + 1);

   localparam logic [63:0] DISP_LIMIT = 64'd100000000000;
   localparam logic [SUM_BITS-1:0] SUM_ALL_ONES = '1;

   typedef enum logic [2:0] {
      CSR_MODE_CODE      = 3'd0,
      CSR_BULK_LENGTH    = 3'd1,
      CSR_PACKET_BYTES   = 3'd2,
      CSR_SAMPLE_TARGET  = 3'd3,
      CSR_UTILIZATION    = 3'd4,
      CSR_INITIAL_GAP    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_CAP_MUL,
      ST_CAP_DIV,
      ST_GAP_DIV,
      ST_COMMIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

>>> rtl/packet_bulk_capacity_estimator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_bulk_capacity_estimator_core: probe-bulk capacity estimator
// Per-slot timestamp tables, bulk tracking, and capacity/gap computation
// on completed bulks through one shared sequential divider.
// ----------------------------------------------------------------------------
// Flow: every item passes read, evaluate, commit and output; a good completed
// bulk adds a capacity division, and a gap division when it sets a new minimum
// RTT sum. One item at a time: the next item can be taken from the cycle after
// the result leaves.
// Reset: synchronous; clears slot tables through valid bits, loads register
// defaults and returns to idle.
module packet_bulk_capacity_estimator_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_op,
   input  wire  [47:0] req_time_ns,
   input  wire  [15:0] req_slot_number,
   input  wire  [3:0]  req_packet_mode,
   input  wire  [9:0]  req_bulk_size_field,
   input  wire  [9:0]  req_seq_in_bulk,
   input  wire  [15:0] req_bulk_number,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_bulk_complete,
   output logic        rsp_sample_good,
   output logic signed [48:0] rsp_dispersion_ns,
   output logic [39:0] rsp_sample_capacity_kbps,
   output logic [39:0] rsp_best_capacity_kbps,
   output logic [31:0] rsp_gap_us,
   output logic [15:0] rsp_good_samples,
   output logic [31:0] rsp_received_count,
   output logic [15:0] rsp_request_number,
   output logic        rsp_done_res,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_data
);
   import pbce_pkg::*;

   // configuration
   logic [3:0]  mode_ff;
   logic [9:0]  blen_ff;
   logic [13:0] pbytes_ff;
   logic [15:0] target_ff;
   logic [8:0]  util_ff;

   // slot tables
   logic [TIME_BITS-1:0] send_mem  [SLOTS];
   logic [TIME_BITS-1:0] first_mem [SLOTS];
   logic [19:0]          seq_mem   [SLOTS];
   logic [SLOTS-1:0]     send_vld_ff, seq_vld_ff, first_vld_ff;
   logic [TIME_BITS-1:0] send_rd_ff, first_rd_ff;
   logic [19:0]          seq_rd_ff;

   // scalar state
   logic [SUM_BITS-1:0] best_sum_ff;
   logic [CAP_BITS-1:0] best_cap_ff;
   logic [GAP_BITS-1:0] gap_ff;
   logic [15:0]         good_ff;
   logic [31:0]         total_ff;
   logic [15:0]         reqnum_ff;
   logic                fin_ff;

   // item registers
   logic                 op_ff;
   logic [TIME_BITS-1:0] t_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [3:0]           pmode_ff;
   logic [9:0]           bsize_ff;
   logic [9:0]           seq_ff;
   logic [15:0]          bnum_ff;

   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [63:0]          disp_ff, disp_in;
   logic [63:0]          bits_ff, bits_in;
   logic [CAP_BITS-1:0]  cap_ff, cap_in;
   logic                 acc_ff, acc_in;
   logic                 cmp_ff, cmp_in;
   logic                 good_s_ff, good_s_in;
   logic                 newmin_ff, newmin_in;

   state_type state_ff, state_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic req_fire, csr_fire, rsp_fire;
   logic [TIME_BITS-1:0] send_v, first_v;
   logic [9:0]           exp_v, last_v;
   logic [SUM_BITS-1:0]  rsum, s2;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;

   pbce_divider u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign send_v  = send_vld_ff[slot_ff]  ? send_rd_ff  : '0;
   assign first_v = first_vld_ff[slot_ff] ? first_rd_ff : '0;
   assign exp_v   = seq_vld_ff[slot_ff] ? seq_rd_ff[19:10] : '0;
   assign last_v  = seq_vld_ff[slot_ff] ? seq_rd_ff[9:0]   : '0;
   assign rsum    = SUM_BITS'(first_v) + SUM_BITS'(t_ff);
   assign s2      = {1'b0, send_v, 1'b0};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) state_in = ST_READ;
         ST_READ:    state_in = ST_EVAL;
         ST_EVAL:    state_in = (cmp_in && good_s_in) ? ST_CAP_MUL : ST_COMMIT;
         ST_CAP_MUL: state_in = ST_CAP_DIV;
         ST_CAP_DIV: if (div_rsp.done) state_in = newmin_ff ? ST_GAP_DIV : ST_COMMIT;
         ST_GAP_DIV: if (div_rsp.done) state_in = ST_COMMIT;
         ST_COMMIT:  state_in = ST_OUT;
         ST_OUT:     if (rsp_fire) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      acc_in    = acc_ff;
      cmp_in    = cmp_ff;
      good_s_in = good_s_ff;
      newmin_in = newmin_ff;
      sum_in    = sum_ff;
      disp_in   = disp_ff;
      bits_in   = bits_ff;
      cap_in    = cap_ff;
      div_req   = '0;
      unique case (state_ff)
         ST_EVAL: begin
            acc_in    = op_ff && !fin_ff && (seq_ff <= blen_ff)
                        && ({1'b0, bnum_ff} <= {1'b0, target_ff}) && (pmode_ff == mode_ff);
            cmp_in    = acc_in && (seq_ff != '0) && (seq_ff == last_v + 10'd1)
                        && (seq_ff == exp_v);
            disp_in   = 64'(t_ff) - 64'(first_v);
            sum_in    = (rsum >= s2) ? (rsum - s2) : '0;
            good_s_in = (t_ff > first_v) && (disp_in < DISP_LIMIT);
            newmin_in = (sum_in < best_sum_ff);
            bits_in   = 64'({15'(pbytes_ff) + 15'(HEADER_BYTES), 3'b000}) * 64'(blen_ff);
         end
         ST_CAP_MUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(bits_ff[31:0]) * 64'(32'd1000000);
            div_req.divisor  = disp_ff;
         end
         ST_CAP_DIV: begin
            if (div_rsp.done) begin
               cap_in = (div_rsp.quotient > 64'(40'hFF_FFFF_FFFF)) ? '1
                        : div_rsp.quotient[CAP_BITS-1:0];
               if (newmin_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {disp_ff[54:0], 9'd0};
                  div_req.divisor  = 64'(util_ff) * 64'd1000;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_op;
         t_ff     <= req_time_ns;
         slot_ff  <= req_slot_number[SLOT_BITS-1:0];
         pmode_ff <= req_packet_mode;
         bsize_ff <= req_bulk_size_field;
         seq_ff   <= req_seq_in_bulk;
         bnum_ff  <= req_bulk_number;
      end
      if (state_ff == ST_READ) begin
         send_rd_ff  <= send_mem[slot_ff];
         first_rd_ff <= first_mem[slot_ff];
         seq_rd_ff   <= seq_mem[slot_ff];
      end
      if (state_ff == ST_COMMIT) begin
         if (!op_ff) begin
            send_mem[slot_ff] <= t_ff;
         end else if (acc_ff && seq_ff == '0) begin
            first_mem[slot_ff] <= t_ff;
            seq_mem[slot_ff]   <= {bsize_ff, 10'd0};
         end else if (acc_ff && seq_ff == last_v + 10'd1) begin
            seq_mem[slot_ff]   <= {exp_v, seq_ff};
         end
      end
      acc_ff    <= acc_in;
      cmp_ff    <= cmp_in;
      good_s_ff <= good_s_in;
      newmin_ff <= newmin_in;
      sum_ff    <= sum_in;
      disp_ff   <= disp_in;
      bits_ff   <= bits_in;
      cap_ff    <= cap_in;
      if (state_ff == ST_COMMIT) begin
         rsp_accepted      <= acc_ff;
         rsp_bulk_complete <= cmp_ff;
         rsp_sample_good   <= cmp_ff && good_s_ff;
         rsp_dispersion_ns <= cmp_ff ? disp_ff[DISP_BITS-1:0] : '0;
         rsp_sample_capacity_kbps <= (cmp_ff && good_s_ff) ? cap_ff : '0;
      end
   end

   always_comb begin
      rsp_best_capacity_kbps = best_cap_ff;
      rsp_gap_us             = gap_ff;
      rsp_good_samples       = good_ff;
      rsp_received_count     = total_ff;
      rsp_request_number     = reqnum_ff;
      rsp_done_res           = fin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 4'd3;
         blen_ff      <= 10'd100;
         pbytes_ff    <= 14'd1500;
         target_ff    <= 16'd200;
         util_ff      <= 9'd26;
         send_vld_ff  <= '0;
         first_vld_ff <= '0;
         seq_vld_ff   <= '0;
         best_sum_ff  <= SUM_ALL_ONES;
         best_cap_ff  <= '0;
         gap_ff       <= 32'd10000;
         good_ff      <= '0;
         total_ff     <= '0;
         reqnum_ff    <= 16'd1;
         fin_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            unique case (csr_index)
               CSR_MODE_CODE:     mode_ff   <= csr_data[3:0];
               CSR_BULK_LENGTH:   blen_ff   <= csr_data[9:0];
               CSR_PACKET_BYTES:  pbytes_ff <= csr_data[13:0];
               CSR_SAMPLE_TARGET: target_ff <= csr_data[15:0];
               CSR_UTILIZATION:   util_ff   <= csr_data[8:0];
               CSR_INITIAL_GAP: begin
                  if (best_sum_ff == SUM_ALL_ONES) gap_ff <= csr_data;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_GAP_DIV && div_rsp.done) begin
            gap_ff <= (div_rsp.quotient > 64'(32'hFFFF_FFFF)) ? '1
                      : div_rsp.quotient[GAP_BITS-1:0];
         end
         if (state_ff == ST_COMMIT) begin
            if (!op_ff) begin
               send_vld_ff[slot_ff] <= 1'b1;
            end else if (acc_ff) begin
               total_ff <= total_ff + 32'd1;
               if (seq_ff == '0) begin
                  first_vld_ff[slot_ff] <= 1'b1;
                  seq_vld_ff[slot_ff]   <= 1'b1;
               end else if (seq_ff == last_v + 10'd1) begin
                  if (cmp_ff) begin
                     reqnum_ff <= reqnum_ff + 16'd1;
                     if (good_s_ff) begin
                        if (good_ff != 16'hFFFF) good_ff <= good_ff + 16'd1;
                        if (newmin_ff) begin
                           best_sum_ff <= sum_ff;
                           best_cap_ff <= cap_ff;
                        end
                     end
                  end
                  if (((cmp_ff && good_s_ff && good_ff != 16'hFFFF)
                       ? good_ff + 16'd1 : good_ff) >= target_ff) fin_ff <= 1'b1;
               end
            end
         end
      end
   end

   ap_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while result pending");
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
   ap_good_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_good |-> rsp_bulk_complete && rsp_accepted)
      else $error("good sample without completion");
   ap_one_div: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy || div_rsp.done || state_ff == ST_CAP_DIV)
      else $error("divider restarted while busy");

endmodule
`default_nettype wire

>>> rtl/pbce_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbce_divider: shared radix-2 restoring divider
// One quotient bit per cycle; quotient saturates to all ones on zero divisor.
// ----------------------------------------------------------------------------
module pbce_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  pbce_pkg::div_req_type req,
   output pbce_pkg::div_rsp_type rsp
);
   import pbce_pkg::*;

   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_BITS:0]   trial;
   logic [DIV_BITS:0]   diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         cnt_in  = CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_BITS]) begin
            rem_in = diff[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire
